@@ design/smpg_pkg.sv @@
// smpg_pkg: shared types, codes and reset constants for the stepper pulse generator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package smpg_pkg;

    localparam int MAX_AXES       = 3;
    localparam int AXIS_COUNT_DEF = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    typedef enum logic [2:0] {
        MODE_TICK    = 3'd0,
        MODE_REL     = 3'd1,
        MODE_ABS     = 3'd2,
        MODE_STOP    = 3'd3,
        MODE_ENABLE  = 3'd4,
        MODE_DISABLE = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_ACCEPTED = 3'd1,
        ST_BUSY     = 3'd2,
        ST_INVALID  = 3'd3,
        ST_DONE     = 3'd4,
        ST_STOPPED  = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_WIDTH    = 3'd0,
        CFG_INTERVAL_FLOOR = 3'd1,
        CFG_AXIS0_MIN      = 3'd2,
        CFG_AXIS1_MIN      = 3'd3,
        CFG_AXIS2_MIN      = 3'd4,
        CFG_ENABLE_LOW     = 3'd5,
        CFG_DIR_POSITIVE   = 3'd6
    } cfg_idx_t;

    localparam logic [7:0]          PULSE_WIDTH_RST    = 8'd10;
    localparam logic [15:0]         INTERVAL_FLOOR_RST = 16'd50;
    localparam logic [31:0]         MIN_INTERVAL_RST   = 32'd50;
    localparam logic [MAX_AXES-1:0] ENABLE_LOW_RST     = 3'b111;
    localparam logic [MAX_AXES-1:0] DIR_POSITIVE_RST   = 3'b111;

    typedef struct packed {
        logic [7:0]                 pulse_width;
        logic [15:0]                interval_floor;
        logic [MAX_AXES-1:0][31:0]  min_interval;
        logic [MAX_AXES-1:0]        enable_low;
        logic [MAX_AXES-1:0]        dir_positive;
    } cfg_t;

    function automatic logic [31:0] umax32(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

@@ design/smpg_cmd_if.sv @@
// smpg_cmd_if: command channel (tick, move, stop, enable, disable) with valid/ready
// uses no package
`timescale 1ns / 1ps
`default_nettype none

interface smpg_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic [1:0]         axis;
    logic signed [31:0] step_amount;
    logic [31:0]        interval;

    modport source (output valid, output mode, output axis, output step_amount,
                    output interval, input ready);
    modport sink   (input valid, input mode, input axis, input step_amount,
                    input interval, output ready);
endinterface

`default_nettype wire

@@ design/smpg_res_if.sv @@
// smpg_res_if: result channel carrying pin levels and status with valid/ready
// uses no package
`timescale 1ns / 1ps
`default_nettype none

interface smpg_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         step_pins;
    logic [2:0]         dir_pins;
    logic [2:0]         enable_pins;
    logic               busy_res;
    logic [1:0]         run_axis;
    logic               all_enabled;
    logic signed [31:0] position;
    logic [2:0]         status;

    modport source (output valid, output step_pins, output dir_pins, output enable_pins,
                    output busy_res, output run_axis, output all_enabled,
                    output position, output status, input ready);
    modport sink   (input valid, input step_pins, input dir_pins, input enable_pins,
                    input busy_res, input run_axis, input all_enabled,
                    input position, input status, output ready);
endinterface

`default_nettype wire

@@ design/smpg_cfg_if.sv @@
// smpg_cfg_if: configuration write channel, register index and data
// uses no package
`timescale 1ns / 1ps
`default_nettype none

interface smpg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/smpg_cfg.sv @@
// smpg_cfg: configuration register file for the stepper pulse generator
// depends on smpg_pkg and smpg_cfg_if
`timescale 1ns / 1ps
`default_nettype none

module smpg_cfg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    smpg_cfg_if.sink          cfg,
    output smpg_pkg::cfg_t    regs
);
    import smpg_pkg::*;

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.pulse_width    <= PULSE_WIDTH_RST;
            regs_reg.interval_floor <= INTERVAL_FLOOR_RST;
            for (int k = 0; k < MAX_AXES; k++)
            begin
                regs_reg.min_interval[k] <= MIN_INTERVAL_RST;
            end
            regs_reg.enable_low     <= ENABLE_LOW_RST;
            regs_reg.dir_positive   <= DIR_POSITIVE_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_PULSE_WIDTH:    regs_reg.pulse_width     <= cfg.data[7:0];
                CFG_INTERVAL_FLOOR: regs_reg.interval_floor  <= cfg.data[15:0];
                CFG_AXIS0_MIN:      regs_reg.min_interval[0] <= cfg.data;
                CFG_AXIS1_MIN:      regs_reg.min_interval[1] <= cfg.data;
                CFG_AXIS2_MIN:      regs_reg.min_interval[2] <= cfg.data;
                CFG_ENABLE_LOW:     regs_reg.enable_low      <= cfg.data[MAX_AXES-1:0];
                CFG_DIR_POSITIVE:   regs_reg.dir_positive    <= cfg.data[MAX_AXES-1:0];
                default:            ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/smpg_core.sv @@
// smpg_core: command register, motion state update and result register
// depends on smpg_pkg, smpg_cmd_if and smpg_res_if
`timescale 1ns / 1ps
`default_nettype none

module smpg_core #(
    parameter int AXIS_COUNT = smpg_pkg::AXIS_COUNT_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire smpg_pkg::cfg_t regs,
    smpg_cmd_if.sink          cmd,
    smpg_res_if.source        res
);
    import smpg_pkg::*;

    localparam int NUM_AXES = (AXIS_COUNT < MAX_AXES) ? AXIS_COUNT : MAX_AXES;
    localparam logic [MAX_AXES-1:0] AXIS_BITS = MAX_AXES'((1 << NUM_AXES) - 1);

    // command register
    logic        in_valid_reg;
    logic [2:0]  mode_reg;
    logic [1:0]  axis_reg;
    logic [31:0] amount_reg;
    logic [31:0] interval_reg;

    // motion state
    logic                moving_reg,   moving_next;
    logic [1:0]          mv_axis_reg,  mv_axis_next;
    logic                neg_reg,      neg_next;
    logic [31:0]         rem_reg,      rem_next;
    logic [31:0]         timer_reg,    timer_next;
    logic [31:0]         period_reg,   period_next;
    logic                pulse_reg,    pulse_next;
    logic [MAX_AXES-1:0] axis_en_reg,  axis_en_next;
    logic [MAX_AXES-1:0] dir_reg,      dir_next;
    logic                flag_reg,     flag_next;
    logic [31:0]         pos_reg  [NUM_AXES];
    logic [31:0]         pos_next [NUM_AXES];

    // result register
    logic                res_valid_reg;
    logic [2:0]          step_pins_reg, step_pins_next;
    logic [2:0]          dir_pins_reg,  dir_pins_next;
    logic [2:0]          en_pins_reg,   en_pins_next;
    logic                busy_reg;
    logic [1:0]          act_axis_reg,  act_axis_next;
    logic                all_en_reg;
    logic [31:0]         position_reg,  position_next;
    status_t             status_reg,    status_next;

    logic advance, fire;

    logic [31:0]         eff_pw;
    logic                axis_ok;
    logic [31:0]         pos_sel;
    logic [31:0]         min_sel;
    logic [31:0]         delta;
    logic [31:0]         delta_mag;
    logic [31:0]         period_new;
    logic [MAX_AXES-1:0] axis_bit;
    logic                count_step;

    logic                tk_fall;
    logic [31:0]         tk_rem;
    logic                tk_wrap;
    logic [31:0]         tk_t0;
    logic                tk_done;

    assign advance   = !res_valid_reg || res.ready;
    assign fire      = in_valid_reg && advance;
    assign cmd.ready = !in_valid_reg || advance;

    assign eff_pw  = (regs.pulse_width == 8'd0) ? 32'd1 : {24'd0, regs.pulse_width};
    assign axis_ok = int'(axis_reg) < NUM_AXES;

    always_comb
    begin
        pos_sel = 32'd0;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            if (axis_reg == 2'(k))
            begin
                pos_sel = pos_reg[k];
            end
        end
        min_sel = 32'd0;
        for (int k = 0; k < MAX_AXES; k++)
        begin
            if (axis_reg == 2'(k))
            begin
                min_sel = regs.min_interval[k];
            end
        end
    end

    assign delta      = (mode_reg == MODE_ABS) ? (amount_reg - pos_sel) : amount_reg;
    assign delta_mag  = delta[31] ? (32'd0 - delta) : delta;
    assign period_new = umax32(umax32(interval_reg, min_sel),
                               umax32({16'd0, regs.interval_floor}, eff_pw));
    assign axis_bit   = MAX_AXES'(1) << axis_reg;

    // tick: falling edge of pulse, end of period, next rising edge
    assign tk_fall = pulse_reg && (timer_reg >= eff_pw);
    assign tk_rem  = tk_fall ? (rem_reg - 32'd1) : rem_reg;
    assign tk_wrap = timer_reg >= period_reg;
    assign tk_t0   = tk_wrap ? 32'd0 : timer_reg;
    assign tk_done = tk_wrap && (tk_rem == 32'd0);

    always_comb
    begin
        moving_next  = moving_reg;
        mv_axis_next = mv_axis_reg;
        neg_next     = neg_reg;
        rem_next     = rem_reg;
        timer_next   = timer_reg;
        period_next  = period_reg;
        pulse_next   = pulse_reg;
        axis_en_next = axis_en_reg;
        dir_next     = dir_reg;
        flag_next    = flag_reg;
        status_next  = ST_NONE;
        count_step   = 1'b0;

        case (mode_reg)
            MODE_TICK:
            begin
                if (moving_reg)
                begin
                    count_step = tk_fall;
                    rem_next   = tk_rem;
                    if (tk_done)
                    begin
                        moving_next = 1'b0;
                        timer_next  = 32'd0;
                        pulse_next  = pulse_reg && !tk_fall;
                        status_next = ST_DONE;
                    end
                    else
                    begin
                        pulse_next = ((tk_t0 == 32'd0) && (tk_rem != 32'd0)) ? 1'b1
                                     : (pulse_reg && !tk_fall);
                        timer_next = tk_t0 + 32'd1;
                    end
                end
            end
            MODE_REL, MODE_ABS:
            begin
                if (!axis_ok)
                begin
                    status_next = ST_INVALID;
                end
                else if (delta == 32'd0)
                begin
                    status_next = ST_ACCEPTED;
                end
                else if (interval_reg == 32'd0)
                begin
                    status_next = ST_INVALID;
                end
                else if (moving_reg)
                begin
                    status_next = ST_BUSY;
                end
                else
                begin
                    moving_next  = 1'b1;
                    mv_axis_next = axis_reg;
                    neg_next     = delta[31];
                    rem_next     = delta_mag;
                    timer_next   = 32'd0;
                    period_next  = period_new;
                    pulse_next   = 1'b0;
                    axis_en_next = axis_en_reg | axis_bit;
                    if (delta[31] == |(regs.dir_positive & axis_bit))
                    begin
                        dir_next = dir_reg & ~axis_bit;
                    end
                    else
                    begin
                        dir_next = dir_reg | axis_bit;
                    end
                    status_next  = ST_ACCEPTED;
                end
            end
            MODE_STOP:
            begin
                if (moving_reg)
                begin
                    count_step = pulse_reg;
                    rem_next   = pulse_reg ? (rem_reg - 32'd1) : rem_reg;
                    status_next = (rem_next == 32'd0) ? ST_DONE : ST_STOPPED;
                end
                moving_next  = 1'b0;
                pulse_next   = 1'b0;
                axis_en_next = '0;
                flag_next    = 1'b0;
            end
            MODE_ENABLE:
            begin
                axis_en_next = AXIS_BITS;
                flag_next    = 1'b1;
                status_next  = ST_ACCEPTED;
            end
            MODE_DISABLE:
            begin
                axis_en_next = '0;
                flag_next    = 1'b0;
                status_next  = ST_ACCEPTED;
            end
            default:
            begin
                status_next = ST_NONE;
            end
        endcase
    end

    // position update and query of the state after this request
    always_comb
    begin
        position_next = 32'd0;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            pos_next[k] = pos_reg[k];
            if (count_step && (mv_axis_reg == 2'(k)))
            begin
                pos_next[k] = neg_reg ? (pos_reg[k] - 32'd1) : (pos_reg[k] + 32'd1);
            end
            if (axis_reg == 2'(k))
            begin
                position_next = pos_next[k];
            end
        end
    end

    assign step_pins_next = (moving_next && pulse_next) ? (MAX_AXES'(1) << mv_axis_next)
                                                        : '0;
    assign dir_pins_next  = dir_next & AXIS_BITS;
    assign en_pins_next   = (axis_en_next ^ regs.enable_low) & AXIS_BITS;
    assign act_axis_next  = moving_next ? mv_axis_next : 2'd3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            moving_reg    <= 1'b0;
            mv_axis_reg   <= 2'd0;
            neg_reg       <= 1'b0;
            rem_reg       <= 32'd0;
            timer_reg     <= 32'd0;
            period_reg    <= 32'd0;
            pulse_reg     <= 1'b0;
            axis_en_reg   <= '0;
            dir_reg       <= '0;
            flag_reg      <= 1'b0;
            for (int k = 0; k < NUM_AXES; k++)
            begin
                pos_reg[k] <= 32'd0;
            end
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                moving_reg  <= moving_next;
                mv_axis_reg <= mv_axis_next;
                neg_reg     <= neg_next;
                rem_reg     <= rem_next;
                timer_reg   <= timer_next;
                period_reg  <= period_next;
                pulse_reg   <= pulse_next;
                axis_en_reg <= axis_en_next;
                dir_reg     <= dir_next;
                flag_reg    <= flag_next;
                for (int k = 0; k < NUM_AXES; k++)
                begin
                    pos_reg[k] <= pos_next[k];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            mode_reg     <= cmd.mode;
            axis_reg     <= cmd.axis;
            amount_reg   <= cmd.step_amount;
            interval_reg <= cmd.interval;
        end
        if (fire)
        begin
            step_pins_reg <= step_pins_next;
            dir_pins_reg  <= dir_pins_next;
            en_pins_reg   <= en_pins_next;
            busy_reg      <= moving_next;
            act_axis_reg  <= act_axis_next;
            all_en_reg    <= flag_next;
            position_reg  <= position_next;
            status_reg    <= status_next;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.step_pins   = step_pins_reg;
    assign res.dir_pins    = dir_pins_reg;
    assign res.enable_pins = en_pins_reg;
    assign res.busy_res    = busy_reg;
    assign res.run_axis    = act_axis_reg;
    assign res.all_enabled = all_en_reg;
    assign res.position    = position_reg;
    assign res.status      = status_reg;

endmodule

`default_nettype wire

@@ design/stepper_move_pulse_generator.sv @@
// stepper_move_pulse_generator: step/dir/enable generator for up to three axes
// depends on smpg_pkg, the three channel interfaces, smpg_cfg and smpg_core
// a request is held in the command register, then its result in the result register
// throughput: one request per cycle while results are taken, set by the combinational motion state update
// a stalled result is held in the result register while one more request is taken
// reset: asynchronous, clears motion state, positions and config to defaults
`timescale 1ns / 1ps
`default_nettype none

module stepper_move_pulse_generator #(
    parameter int AXIS_COUNT = smpg_pkg::AXIS_COUNT_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    smpg_cmd_if.sink   cmd,
    smpg_res_if.source res,
    smpg_cfg_if.sink   cfg
);
    import smpg_pkg::*;

    cfg_t regs;

    smpg_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    smpg_core #(
        .AXIS_COUNT (AXIS_COUNT)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .regs  (regs),
        .cmd   (cmd),
        .res   (res)
    );

endmodule

`default_nettype wire

@@ design/smpg_chk.sv @@
// smpg_chk: port-level checks on the result channel of the pulse generator
// depends on smpg_pkg; bound to stepper_move_pulse_generator below
`timescale 1ns / 1ps
`default_nettype none

module smpg_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [2:0] step_pins,
    input wire logic       busy_res,
    input wire logic [1:0] run_axis,
    input wire logic [2:0] status
);
    import smpg_pkg::*;

    // stalled result stays
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // idle means no axis and no step pulse
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !busy_res |-> (run_axis == 2'd3) && (step_pins == 3'd0))
        else $error("step activity while idle");

    // only one axis steps at a time
    a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $onehot0(step_pins))
        else $error("more than one step pin high");

    // end of move leaves the block idle
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ST_DONE || status == ST_STOPPED) |-> !busy_res)
        else $error("move ended but still busy");

endmodule

bind stepper_move_pulse_generator smpg_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .step_pins   (res.step_pins),
    .busy_res    (res.busy_res),
    .run_axis    (res.run_axis),
    .status      (res.status)
);

`default_nettype wire
